>>> design/trdf_pkg.sv
// ----------------------------------------------------------------------------
// trdf_pkg
// Shared types and constants for the tape image record deframer.
// ----------------------------------------------------------------------------
package trdf_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 32;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 1;
    localparam int FIELD_BYTES = LEN_W / BYTE_W;
    localparam int FBI_W   = $clog2(FIELD_BYTES);

    // Configuration reset values
    localparam logic             PAD_ODD_RESET = 1'b1;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65535;

    // Output tdata width: data_byte and record_length, padded to bytes
    localparam int OUT_DATA_BITS = BYTE_W + LEN_W;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PAD_ODD_RECORDS = 1'd0,
        REG_MAX_RECORD_LEN  = 1'd1
    } reg_idx_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA    = 3'd0,
        KIND_MARK    = 3'd1,
        KIND_END     = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_CORRUPT = 3'd4
    } kind_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_DATA    = 3'd1,
        PH_PAD     = 3'd2,
        PH_TRAILER = 3'd3,
        PH_HALTED  = 3'd4
    } phase_t;

    // Live configuration
    typedef struct packed {
        logic             pad_odd;
        logic [LEN_W-1:0] max_len;
    } cfg_t;

    // One result from the parser
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  record_length;
    } result_t;

endpackage

>>> design/tape_image_record_deframer_core.sv
// ----------------------------------------------------------------------------
// tape_image_record_deframer_core
// Splits a tape image byte stream into record data, tape marks and errors.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and sustains that rate under no
// backpressure. A byte is captured in an input register and stepped through
// the framing state machine once the result register can take its result;
// its result, if any, lands in the output register at that step. A result
// held by the sink keeps the input register full, and input ready then
// follows the result side's ready. Header, pad and trailer bytes produce
// nothing except the last byte of a length field. After a too-long or
// corrupt-trailer error the block drops all bytes until reset. Configuration
// writes take effect immediately and are expected only while the block is
// idle.
module tape_image_record_deframer_core
    import trdf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] stream_byte

    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [39:8] record_length
    output logic [KIND_W-1:0]      m_axis_tuser,   // [2:0] kind

    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [LEN_W-1:0]       cfg_data
);

    cfg_t              cfg;
    result_t           res;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [LEN_W-1:0]  out_len_reg;

    assign cfg_ready = 1'b1;

    trdf_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Held byte moves on when the result register can take its result
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    trdf_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .stream_byte (in_byte_reg),
        .cfg         (cfg),
        .res         (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_kind_reg <= res.kind;
            out_byte_reg <= res.data_byte;
            out_len_reg  <= res.record_length;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_len_reg, out_byte_reg});

endmodule

>>> design/trdf_cfg.sv
// ----------------------------------------------------------------------------
// trdf_cfg
// Configuration register file: pad mode and record length limit.
// ----------------------------------------------------------------------------
module trdf_cfg
    import trdf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_index,
    input  logic [LEN_W-1:0]    wr_data,
    output cfg_t                cfg
);

    logic             pad_odd_reg;
    logic [LEN_W-1:0] max_len_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_odd_reg <= PAD_ODD_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_PAD_ODD_RECORDS: pad_odd_reg <= wr_data[0];
                REG_MAX_RECORD_LEN:  max_len_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg.pad_odd = pad_odd_reg;
    assign cfg.max_len = max_len_reg;

endmodule

>>> design/trdf_parser.sv
// ----------------------------------------------------------------------------
// trdf_parser
// Record framing state machine: one stream byte per step, at most one result.
// ----------------------------------------------------------------------------
module trdf_parser
    import trdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] stream_byte,
    input  cfg_t              cfg,
    output result_t           res
);

    phase_t            phase_reg,   phase_next;
    logic [FBI_W-1:0]  fbi_reg,     fbi_next;
    logic [LEN_W-1:0]  header_reg,  header_next;
    logic [LEN_W-1:0]  remain_reg,  remain_next;
    logic [LEN_W-1:0]  trailer_reg, trailer_next;

    logic [LEN_W-1:0]  field_base;
    logic [LEN_W-1:0]  field_val;
    logic [LEN_W-1:0]  remain_dec;
    logic              last_byte;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            fbi_reg     <= '0;
            header_reg  <= '0;
            remain_reg  <= '0;
            trailer_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            fbi_reg     <= fbi_next;
            header_reg  <= header_next;
            remain_reg  <= remain_next;
            trailer_reg <= trailer_next;
        end
    end

    // Length field assembly, little endian; first byte clears the field
    always_comb
    begin
        field_base = (phase_reg == PH_TRAILER) ? trailer_reg : header_reg;
        if (fbi_reg == '0)
            field_base = '0;
        field_val = field_base;
        field_val[fbi_reg*BYTE_W +: BYTE_W] = stream_byte;
    end

    assign last_byte  = (fbi_reg == FBI_W'(FIELD_BYTES - 1));
    assign remain_dec = remain_reg - LEN_W'(1);

    // Next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        fbi_next     = fbi_reg;
        header_next  = header_reg;
        remain_next  = remain_reg;
        trailer_next = trailer_reg;
        res          = '0;
        res.kind     = KIND_DATA;

        case (phase_reg)
            PH_HEADER:
            begin
                header_next = field_val;
                fbi_next    = fbi_reg + FBI_W'(1);
                if (last_byte)
                begin
                    if (field_val == '0)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_MARK;
                    end
                    else if (field_val > cfg.max_len)
                    begin
                        phase_next        = PH_HALTED;
                        res.valid         = 1'b1;
                        res.kind          = KIND_LONG;
                        res.record_length = field_val;
                    end
                    else
                    begin
                        remain_next = field_val;
                        phase_next  = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                remain_next   = remain_dec;
                res.valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = stream_byte;
                if (remain_dec == '0)
                begin
                    phase_next   = (cfg.pad_odd && header_reg[0]) ? PH_PAD : PH_TRAILER;
                    fbi_next     = '0;
                    trailer_next = '0;
                end
            end
            PH_PAD:
            begin
                phase_next   = PH_TRAILER;
                fbi_next     = '0;
                trailer_next = '0;
            end
            PH_TRAILER:
            begin
                trailer_next = field_val;
                fbi_next     = fbi_reg + FBI_W'(1);
                if (last_byte)
                begin
                    res.valid         = 1'b1;
                    res.record_length = header_reg;
                    if (field_val != header_reg)
                    begin
                        phase_next = PH_HALTED;
                        res.kind   = KIND_CORRUPT;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        res.kind   = KIND_END;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HALTED;
            end
        endcase
    end

endmodule

>>> test/trdf_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdf_stream_checker
// Watches the deframer's byte, result and configuration channels, predicts
// every result word from the accepted stream bytes and compares in order.
// ----------------------------------------------------------------------------
module trdf_stream_checker
    import trdf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] stream_byte

    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [39:8] record_length
    input  logic [KIND_W-1:0]      m_axis_tuser,   // [2:0] kind

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [LEN_W-1:0]       cfg_data,

    output int                     fail_count,
    output int                     pending,
    output int                     results_seen
);

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  record_length;
    } deframed_word_t;

    deframed_word_t predicted_words[$];

    // Shadow of the live configuration
    logic             pad_odd;
    logic [LEN_W-1:0] max_len;

    // Shadow of the framing state
    phase_t           phase;
    logic [1:0]       field_pos;
    logic [LEN_W-1:0] header_len;
    logic [LEN_W-1:0] left_len;
    logic [LEN_W-1:0] trailer_len;

    // Step the shadow framer by one byte; emit says whether a word comes out
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b,
                                         output bit emit, output deframed_word_t w);
        logic [LEN_W-1:0] shifted;
        shifted = {24'd0, b} << {field_pos, 3'b000};
        emit = 1'b0;
        w = '{KIND_DATA, 8'd0, 32'd0};
        case (phase)
            PH_HEADER:
            begin
                if (field_pos == 2'd0)
                    header_len = '0;
                header_len = header_len | shifted;
                if (field_pos != 2'd3)
                    field_pos = field_pos + 2'd1;
                else
                begin
                    field_pos = 2'd0;
                    emit = 1'b1;
                    if (header_len == '0)
                        w.kind = KIND_MARK;
                    else if (header_len > max_len)
                    begin
                        phase = PH_HALTED;
                        w.kind = KIND_LONG;
                        w.record_length = header_len;
                    end
                    else
                    begin
                        emit = 1'b0;
                        left_len = header_len;
                        phase = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                left_len = left_len - 32'd1;
                if (left_len == '0)
                begin
                    phase = (pad_odd && header_len[0]) ? PH_PAD : PH_TRAILER;
                    field_pos = 2'd0;
                    trailer_len = '0;
                end
                emit = 1'b1;
                w.kind = KIND_DATA;
                w.data_byte = b;
            end
            PH_PAD:
            begin
                phase = PH_TRAILER;
                field_pos = 2'd0;
                trailer_len = '0;
            end
            PH_TRAILER:
            begin
                if (field_pos == 2'd0)
                    trailer_len = '0;
                trailer_len = trailer_len | shifted;
                if (field_pos != 2'd3)
                    field_pos = field_pos + 2'd1;
                else
                begin
                    field_pos = 2'd0;
                    emit = 1'b1;
                    w.record_length = header_len;
                    if (trailer_len != header_len)
                    begin
                        phase = PH_HALTED;
                        w.kind = KIND_CORRUPT;
                    end
                    else
                    begin
                        phase = PH_HEADER;
                        w.kind = KIND_END;
                    end
                end
            end
            default:
                phase = PH_HALTED;
        endcase
    endfunction

    // Compare result words first, then fold in bytes and register writes
    always @(posedge clk or negedge rst_n)
    begin
        deframed_word_t exp_w;
        deframed_word_t new_w;
        bit             emit;
        if (!rst_n)
        begin
            pad_odd      = PAD_ODD_RESET;
            max_len      = MAX_LEN_RESET;
            phase        = PH_HEADER;
            field_pos    = 2'd0;
            header_len   = '0;
            left_len     = '0;
            trailer_len  = '0;
            predicted_words.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (predicted_words.size() == 0)
                begin
                    $error("unexpected result word: kind %0d data_byte 0x%02h length %0d",
                           m_axis_tuser, m_axis_tdata[BYTE_W-1:0],
                           m_axis_tdata[BYTE_W +: LEN_W]);
                    fail_count++;
                end
                else
                begin
                    exp_w = predicted_words.pop_front();
                    if (m_axis_tuser !== exp_w.kind)
                    begin
                        $error("kind: expected %0d, got %0d", exp_w.kind, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[BYTE_W-1:0] !== exp_w.data_byte)
                    begin
                        $error("data_byte: expected 0x%02h, got 0x%02h",
                               exp_w.data_byte, m_axis_tdata[BYTE_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[BYTE_W +: LEN_W] !== exp_w.record_length)
                    begin
                        $error("record_length: expected %0d, got %0d",
                               exp_w.record_length, m_axis_tdata[BYTE_W +: LEN_W]);
                        fail_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_byte(s_axis_tdata, emit, new_w);
                if (emit)
                    predicted_words.push_back(new_w);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PAD_ODD_RECORDS: pad_odd = cfg_data[0];
                    REG_MAX_RECORD_LEN:  max_len = cfg_data;
                    default: ;
                endcase
            end

            pending = predicted_words.size();
        end
    end

endmodule

>>> test/tape_image_record_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_image_record_deframer_core_tb
// Feeds framed tape records, tape marks and pad bytes through the deframer
// under several limit and padding settings with random gaps on both sides,
// and ends the run on a framing error to check the halt behavior.
// ----------------------------------------------------------------------------
module tape_image_record_deframer_core_tb;
    import trdf_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index;
    logic [LEN_W-1:0]       cfg_data;

    int fail_count;
    int pending;
    int results_seen;

    // Stimulus bookkeeping
    int               bytes_sent;
    int               records_sent;
    int               marks_sent;
    bit               sender_calm;
    logic             cur_pad;
    logic [LEN_W-1:0] cur_max;
    string            end_case;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tape_image_record_deframer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    trdf_stream_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    // One stream word, after a random gap unless the sender is in a burst
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(59, 0) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(14, 0);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Little-endian 32-bit length field
    task automatic send_len(input logic [LEN_W-1:0] len);
        for (int i = 0; i < FIELD_BYTES; i++)
            send_byte(len[8*i +: 8]);
    endtask

    // Header, data, optional pad byte, trailer
    task automatic send_record(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] trailer);
        send_len(len);
        for (int i = 0; i < int'(len); i++)
            send_byte(BYTE_W'($urandom_range(255, 0)));
        if (cur_pad && len[0])
            send_byte(BYTE_W'($urandom_range(255, 0)));
        send_len(trailer);
        records_sent++;
    endtask

    // Stop sending and hold off until every predicted word has come out
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [LEN_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_PAD_ODD_RECORDS)
            cur_pad = val[0];
        else
            cur_max = val;
    endtask

    // Record length for the current limit; zero means a tape mark
    function automatic logic [LEN_W-1:0] pick_len(input logic [LEN_W-1:0] lim);
        int               r;
        logic [LEN_W-1:0] cap;
        if (lim == '0)
            return '0;
        r = $urandom_range(99, 0);
        cap = (lim > 32'd24) ? 32'd24 : lim;
        if (r < 10)
            return '0;
        if (r < 16 && lim <= 32'd300)
            return lim;
        if (r < 19)
            cap = (lim > 32'd300) ? 32'd300 : lim;
        return $urandom_range(cap, 1);
    endfunction

    // Result side: random stall after every accepted word, with calm stretches
    initial
    begin : result_sink
        int hold;
        bit calm;
        hold = 0;
        calm = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if ($urandom_range(39, 0) == 0)
                    calm = !calm;
                hold = calm ? 0 : $urandom_range(14, 0);
            end
        end
    end

    initial
    begin : stimulus
        int               phase_no;
        int               n_rec;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] lim;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_PAD_ODD_RECORDS;
        cfg_data      = '0;
        bytes_sent    = 0;
        records_sent  = 0;
        marks_sent    = 0;
        sender_calm   = 1'b0;
        cur_pad       = PAD_ODD_RESET;
        cur_max       = MAX_LEN_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tape mark, padded odd record, even record with byte extremes
        send_len('0);
        marks_sent++;
        send_len(32'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_len(32'd1);
        records_sent++;
        send_len(32'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_len(32'd2);
        records_sent++;

        // Random phases, each under its own limit and padding setting
        phase_no = 0;
        while (bytes_sent < 1425)
        begin
            drain();
            case (phase_no)
                0: lim = '0;
                1: lim = '1;
                default:
                    case ($urandom_range(5, 0))
                        0: lim = '0;
                        1: lim = '1;
                        2, 3: lim = $urandom_range(40, 1);
                        4: lim = $urandom_range(300, 1);
                        default: lim = $urandom;
                    endcase
            endcase
            write_reg(REG_MAX_RECORD_LEN, lim);
            write_reg(REG_PAD_ODD_RECORDS,
                      (phase_no < 2) ? LEN_W'(phase_no) : LEN_W'($urandom_range(1, 0)));
            n_rec = $urandom_range(16, 3);
            for (int i = 0; i < n_rec; i++)
            begin
                len = pick_len(cur_max);
                if (len == '0)
                begin
                    send_len('0);
                    marks_sent++;
                end
                else
                    send_record(len, len);
            end
            phase_no++;
        end

        // One framing error to close the run; later bytes must all be dropped
        drain();
        write_reg(REG_MAX_RECORD_LEN, LEN_W'($urandom_range(1000, 1)));
        if ($urandom_range(1, 0) == 0)
        begin
            end_case = "too-long header";
            send_len($urandom | 32'h8000_0000);
        end
        else
        begin
            end_case = "corrupt trailer";
            len = $urandom_range(24, 1);
            send_record(len, len ^ (32'd1 << $urandom_range(31, 0)));
        end
        repeat (24) send_byte(BYTE_W'($urandom_range(255, 0)));

        drain();
        $display("tb: %0d stream bytes, %0d records, %0d tape marks, %0d result words",
                 bytes_sent, records_sent, marks_sent, results_seen);
        $display("tb: %0d config phases, run ended on a %s", phase_no, end_case);
        if (fail_count == 0 && pending == 0)
            $display("tape_image_record_deframer_core_tb: clean");
        else
        begin
            if (pending != 0)
                $error("%0d predicted result words never arrived", pending);
            $display("tape_image_record_deframer_core_tb: errors");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin : watchdog
        #1_000_000;
        $error("timeout with %0d result words outstanding", pending);
        $display("tape_image_record_deframer_core_tb: errors");
        $finish;
    end

endmodule
